// ----- sv/meu_pkg.sv -----
package meu_pkg;

    localparam int MAX_ENTITY_LEN = 16;
    localparam int CNT_W = $clog2(MAX_ENTITY_LEN + 1);
    localparam int IDX_W = $clog2(MAX_ENTITY_LEN);
    localparam int POS_W = $clog2(MAX_ENTITY_LEN + 7);
    localparam int CODE_W = 31;
    localparam int Q_DEPTH = 2;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_X    = 8'h78;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_AMP,
        MODE_NAMED,
        MODE_HASH,
        MODE_DEC,
        MODE_HEX
    } mode_t;

    typedef enum logic [1:0] {
        ACT_FAIL,
        ACT_EXTEND,
        ACT_DONE
    } act_t;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_LIT,
        TAIL_NAMED,
        TAIL_UTF8
    } tail_t;

    // At most one command per input transaction: replay bytes, then a tail
    typedef struct packed {
        logic [MAX_ENTITY_LEN-1:0][7:0] rep_buf;
        logic [CNT_W-1:0]               rep_cnt;
        tail_t                          tail_kind;
        logic [7:0]                     tail_byte;
        logic [2:0]                     which;
        logic [CODE_W-1:0]              code;
        logic                           last;
    } cmd_t;

    localparam logic [7:0] NAME_TAB [8][5] = '{
        '{"a", "m", "p", ";", 8'h00},
        '{"l", "t", ";", 8'h00, 8'h00},
        '{"g", "t", ";", 8'h00, 8'h00},
        '{"n", "b", "s", "p", ";"},
        '{"c", "o", "p", "y", ";"},
        '{"q", "u", "o", "t", ";"},
        '{"r", "e", "g", ";", 8'h00},
        '{"a", "p", "o", "s", ";"}
    };

    localparam logic [2:0] NAME_LEN [8] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5, 3'd5, 3'd4, 3'd5};

    localparam logic [7:0] REPL_TAB [8][2] = '{
        '{8'h26, 8'h00}, '{8'h3C, 8'h00}, '{8'h3E, 8'h00}, '{8'h20, 8'h00},
        '{8'hC2, 8'hA9}, '{8'h22, 8'h00}, '{8'hC2, 8'hAE}, '{8'h27, 8'h00}
    };

    localparam logic [2:0] REPL_LEN [8] = '{3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd1};

    function automatic logic [7:0] name_char(logic [2:0] i, logic [2:0] k);
        logic [7:0] c;
        c = 8'h00;
        if (k <= 3'd4)
        begin
            c = NAME_TAB[i][k];
        end
        return c;
    endfunction

    function automatic logic [7:0] repl_byte(logic [2:0] i, logic [2:0] t);
        return REPL_TAB[i][t[0]];
    endfunction

    function automatic logic [2:0] utf8_len(logic [CODE_W-1:0] c);
        logic [2:0] n;
        if (c < 31'h80)
            n = 3'd1;
        else if (c < 31'h800)
            n = 3'd2;
        else if (c < 31'h10000)
            n = 3'd3;
        else if (c < 31'h200000)
            n = 3'd4;
        else if (c < 31'h4000000)
            n = 3'd5;
        else
            n = 3'd6;
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte(logic [CODE_W-1:0] c, logic [2:0] n,
                                             logic [2:0] t);
        logic [2:0]        rem;
        logic [4:0]        shamt;
        logic [CODE_W-1:0] sh;
        logic [7:0]        lead;
        logic [7:0]        b;
        rem = n - 3'd1 - t;
        shamt = {rem, 2'b00} + {1'b0, rem, 1'b0};
        sh = c >> shamt;
        case (n)
            3'd2:    lead = 8'hC0;
            3'd3:    lead = 8'hE0;
            3'd4:    lead = 8'hF0;
            3'd5:    lead = 8'hF8;
            3'd6:    lead = 8'hFC;
            default: lead = 8'h00;
        endcase
        if (t == 3'd0)
            b = sh[7:0] | lead;
        else
            b = {2'b10, sh[5:0]};
        return b;
    endfunction

endpackage

// ----- sv/meu_front.sv -----
module meu_front
    import meu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [7:0] byte_in,
    input  logic       string_last,
    output logic       cmd_push,
    output cmd_t       cmd
);

    mode_t                          mode_reg, mode_next;
    logic [MAX_ENTITY_LEN-1:0][7:0] buf_reg, buf_next, buf_ext;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [CODE_W-1:0]              code_reg, code_next;
    logic                           ovf_reg, ovf_next;
    logic [7:0]                     alive_reg, alive_next;

    act_t        act;
    mode_t       tgt;
    logic [3:0]  digit;
    logic        has_digit;
    logic        is_hex;
    logic [7:0]  lc;
    logic [2:0]  k;
    logic [7:0]  ok;
    logic [7:0]  done_hit;
    logic [2:0]  which;
    logic        room;
    logic [35:0] v;
    logic        is_dig;

    // Classify the byte against the current parse mode
    always_comb
    begin
        lc = ((byte_in >= "A") && (byte_in <= "Z")) ? byte_in + 8'd32 : byte_in;
        k = cnt_reg[2:0] - 3'd1;
        is_dig = (byte_in >= "0") && (byte_in <= "9");
        ok = '0;
        done_hit = '0;
        which = '0;
        for (int i = 0; i < 8; i++)
        begin
            ok[i] = alive_reg[i] && (k < NAME_LEN[i]) && (lc == name_char(3'(i), k));
            done_hit[i] = ok[i] && (k + 3'd1 == NAME_LEN[i]);
        end
        for (int i = 7; i >= 0; i--)
        begin
            if (done_hit[i])
                which = 3'(i);
        end
        act = ACT_FAIL;
        tgt = mode_reg;
        digit = '0;
        has_digit = 1'b0;
        is_hex = 1'b0;
        case (mode_reg)
            MODE_AMP, MODE_NAMED:
            begin
                if (mode_reg == MODE_AMP && byte_in == CH_HASH)
                begin
                    act = ACT_EXTEND;
                    tgt = MODE_HASH;
                end
                else
                begin
                    tgt = MODE_NAMED;
                    if (|done_hit)
                        act = ACT_DONE;
                    else if (|ok)
                        act = ACT_EXTEND;
                end
            end
            MODE_HASH:
            begin
                if (byte_in == CH_X)
                begin
                    act = ACT_EXTEND;
                    tgt = MODE_HEX;
                end
                else if (is_dig)
                begin
                    act = ACT_EXTEND;
                    tgt = MODE_DEC;
                    digit = byte_in[3:0];
                    has_digit = 1'b1;
                end
            end
            MODE_DEC:
            begin
                if (is_dig)
                begin
                    act = ACT_EXTEND;
                    digit = byte_in[3:0];
                    has_digit = 1'b1;
                end
                else if (byte_in == CH_SEMI)
                    act = ACT_DONE;
            end
            MODE_HEX:
            begin
                is_hex = 1'b1;
                if (is_dig)
                begin
                    act = ACT_EXTEND;
                    digit = byte_in[3:0];
                    has_digit = 1'b1;
                end
                else if (lc >= "a" && lc <= "f")
                begin
                    act = ACT_EXTEND;
                    digit = lc[3:0] + 4'd9;
                    has_digit = 1'b1;
                end
                else if (byte_in == CH_SEMI)
                    act = ACT_DONE;
            end
            default:
                act = ACT_FAIL;
        endcase
    end

    // Step the parser and build the command for this transaction
    always_comb
    begin
        mode_next = mode_reg;
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        code_next = code_reg;
        ovf_next = ovf_reg;
        alive_next = alive_reg;
        cmd = '0;
        cmd.last = string_last;
        cmd.code = code_reg;
        cmd.which = which;
        cmd.tail_byte = byte_in;
        cmd_push = 1'b0;
        room = cnt_reg < CNT_W'(MAX_ENTITY_LEN);
        buf_ext = buf_reg;
        if (room)
            buf_ext[cnt_reg[IDX_W-1:0]] = byte_in;
        if (is_hex)
            v = {1'b0, code_reg, 4'b0000} + {32'd0, digit};
        else
            v = {2'b00, code_reg, 3'b000} + {4'b0000, code_reg, 1'b0} + {32'd0, digit};

        if (in_fire)
        begin
            if (mode_reg == MODE_IDLE)
            begin
                if (byte_in == CH_AMP && !string_last)
                begin
                    buf_next[0] = CH_AMP;
                    cnt_next = CNT_W'(1);
                    code_next = '0;
                    ovf_next = 1'b0;
                    alive_next = '1;
                    mode_next = MODE_AMP;
                end
                else
                begin
                    cmd.tail_kind = TAIL_LIT;
                    cmd_push = 1'b1;
                end
            end
            else if (act == ACT_DONE && (mode_reg == MODE_AMP || mode_reg == MODE_NAMED))
            begin
                cmd.tail_kind = TAIL_NAMED;
                cmd_push = 1'b1;
                cnt_next = '0;
                mode_next = MODE_IDLE;
            end
            else if (act == ACT_DONE && code_reg != '0 && !ovf_reg)
            begin
                cmd.tail_kind = TAIL_UTF8;
                cmd_push = 1'b1;
                cnt_next = '0;
                mode_next = MODE_IDLE;
            end
            else if (act == ACT_EXTEND && room)
            begin
                if (string_last)
                begin
                    // flush the candidate including this byte
                    cmd.rep_buf = buf_ext;
                    cmd.rep_cnt = cnt_reg + CNT_W'(1);
                    cmd.tail_kind = TAIL_NONE;
                    cmd_push = 1'b1;
                    cnt_next = '0;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    buf_next = buf_ext;
                    cnt_next = cnt_reg + CNT_W'(1);
                    mode_next = tgt;
                    alive_next = ok;
                    if (has_digit && !ovf_reg)
                    begin
                        if (|v[35:31])
                        begin
                            ovf_next = 1'b1;
                            code_next = '0;
                        end
                        else
                            code_next = v[CODE_W-1:0];
                    end
                end
            end
            else
            begin
                // replay the candidate, then rescan the byte from idle
                cmd.rep_buf = buf_reg;
                cmd.rep_cnt = cnt_reg;
                cmd_push = 1'b1;
                cnt_next = '0;
                mode_next = MODE_IDLE;
                if (byte_in == CH_AMP && !string_last)
                begin
                    cmd.tail_kind = TAIL_NONE;
                    buf_next[0] = CH_AMP;
                    cnt_next = CNT_W'(1);
                    code_next = '0;
                    ovf_next = 1'b0;
                    alive_next = '1;
                    mode_next = MODE_AMP;
                end
                else
                    cmd.tail_kind = TAIL_LIT;
            end
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            cnt_reg <= '0;
            code_reg <= '0;
            ovf_reg <= 1'b0;
            alive_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            cnt_reg <= cnt_next;
            code_reg <= code_next;
            ovf_reg <= ovf_next;
            alive_reg <= alive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

// ----- sv/meu_cmd_fifo.sv -----
module meu_cmd_fifo
    import meu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output cmd_t rd_data
);

    localparam int PTR_W = $clog2(Q_DEPTH);

    cmd_t             mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full = count_reg == (PTR_W + 1)'(Q_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data = mem[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + (PTR_W + 1)'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- sv/meu_back.sv -----
module meu_back
    import meu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] byte_out,
    output logic       run_last,
    output logic       string_end
);

    logic [POS_W-1:0] pos_reg;
    logic             out_valid_reg;
    logic [7:0]       byte_reg;
    logic             run_last_reg;
    logic             string_end_reg;

    logic [2:0]       ulen;
    logic [2:0]       tail_len;
    logic [POS_W-1:0] total;
    logic [POS_W-1:0] t_full;
    logic [2:0]       t;
    logic             is_end;
    logic             advance;
    logic [7:0]       cur_byte;

    // Select the byte at the current position of the command
    always_comb
    begin
        ulen = utf8_len(cmd.code);
        case (cmd.tail_kind)
            TAIL_LIT:   tail_len = 3'd1;
            TAIL_NAMED: tail_len = REPL_LEN[cmd.which];
            TAIL_UTF8:  tail_len = ulen;
            default:    tail_len = 3'd0;
        endcase
        total = POS_W'(cmd.rep_cnt) + POS_W'(tail_len);
        is_end = pos_reg == total - POS_W'(1);
        t_full = pos_reg - POS_W'(cmd.rep_cnt);
        t = t_full[2:0];
        if (pos_reg < POS_W'(cmd.rep_cnt))
            cur_byte = cmd.rep_buf[pos_reg[IDX_W-1:0]];
        else
        begin
            case (cmd.tail_kind)
                TAIL_NAMED: cur_byte = repl_byte(cmd.which, t);
                TAIL_UTF8:  cur_byte = utf8_byte(cmd.code, ulen, t);
                default:    cur_byte = cmd.tail_byte;
            endcase
        end
        advance = cmd_valid && (!out_valid_reg || pop);
        cmd_pop = advance && is_end;
    end

    assign empty = !out_valid_reg;
    assign byte_out = byte_reg;
    assign run_last = run_last_reg;
    assign string_end = string_end_reg;

    // Advance through the command and load the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                pos_reg <= is_end ? '0 : pos_reg + POS_W'(1);
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= cur_byte;
            run_last_reg <= is_end;
            string_end_reg <= is_end && cmd.last;
        end
    end

endmodule

// ----- sv/markup_entity_unescaper.sv -----
// A result byte is registered in the command queue and then in the output register.
// Throughput: one input byte per cycle while each yields at most one output byte and pop keeps up;
// a replay or multi-byte replacement holds the back end while its bytes are emitted, and the
// input stalls once the two-entry command queue fills.
// Reset: asynchronous active-low rst_n returns the parser to idle and empties all queues.
module markup_entity_unescaper
    import meu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] byte_in,
    input  logic       string_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] byte_out,
    output logic       run_last,
    output logic       string_end
);

    logic in_fire;
    logic cmd_push;
    cmd_t cmd_in;
    cmd_t cmd_head;
    logic cmd_valid;
    logic cmd_pop;

    assign in_fire = push && !full;

    // Parse and classify input bytes
    meu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .byte_in     (byte_in),
        .string_last (string_last),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    // Decouple parser from emitter
    meu_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (cmd_in),
        .full     (full),
        .rd_en    (cmd_pop),
        .rd_valid (cmd_valid),
        .rd_data  (cmd_head)
    );

    // Expand commands into output bytes
    meu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd_head),
        .cmd_pop    (cmd_pop),
        .empty      (empty),
        .pop        (pop),
        .byte_out   (byte_out),
        .run_last   (run_last),
        .string_end (string_end)
    );

endmodule
